// ----- hw/rtl/hll_pkg.sv -----
package hll_pkg;

    // Default sketch geometry
    localparam int LOG2_REGS_DEF = 14;
    localparam int REG_BITS_DEF  = 6;

    // Fixed word field widths
    localparam int IDX_BITS  = 14;
    localparam int VAL_BITS  = 6;
    localparam int EST_BITS  = 48;
    localparam int ALPHA_BITS = 16;

    // Fraction bits of the harmonic sum
    localparam int FRAC_BITS = 64;

    // Quotient bits produced by the divider, one per step
    localparam int DIV_STEPS = EST_BITS;

    // Reset value of alpha (about 0.72134 in Q16)
    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd47274;

    // Input command codes
    localparam logic CMD_MERGE    = 1'b0;
    localparam logic CMD_ESTIMATE = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic cnt_clr;     // zero the shared counter
        logic cnt_inc;     // advance the shared counter
        logic clr_wr;      // write zero at counter address (clearing pass)
        logic rd_in;       // read address from input index, else counter
        logic merge_cap;   // capture merge index and value
        logic merge_wr;    // write back max of stored and captured value
        logic acc_clr;     // zero the sum accumulator
        logic sum_rd;      // walk read; data accumulates in the next cycle
        logic div_init;    // load remainder and saturation flag
        logic div_step;    // one restoring division step
        logic out_load;    // load result into output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_mem_last;  // counter at last register
        logic cnt_div_last;  // counter at last quotient bit
        logic out_free;      // output register can take a word this cycle
    } t_sts;

endpackage

// ----- hw/rtl/hyperloglog_merge_estimate.sv -----
// HyperLogLog sketch with merge and cardinality estimate.
// Input channel (i_in_valid / o_in_stall): a word carries i_cmd, i_index,
// i_value. A merge word (cmd 0) keeps max(stored, value) in register index;
// it produces no output and takes a registered store read, then a write back.
// An estimate word (cmd 1) walks all 2^LOG2_REGISTERS registers, one store
// read per cycle, summing 2^-r, then runs a restoring divider one quotient
// bit per cycle for 48 bits.
// Output channel (o_out_valid / i_out_stall): one word per estimate with
// o_estimate = floor(alpha*m^2/sum), clamped to 2^48-1 with o_saturated.
// The output register holds its word while i_out_stall is high; merges are
// still taken meanwhile, and a following estimate waits at its end until the
// register frees.
// Config: i_cfg_we writes alpha (Q16) from i_cfg_wdata; write only when idle.
// Reset (i_rst_n low, synchronous) sets alpha to its default and starts a
// clearing pass that zeroes all 2^LOG2_REGISTERS registers of the store;
// o_in_stall stays high until it ends.
module hyperloglog_merge_estimate #(
    parameter int LOG2_REGISTERS = hll_pkg::LOG2_REGS_DEF,
    parameter int REGISTER_BITS  = hll_pkg::REG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_cmd,
    input  logic [hll_pkg::IDX_BITS-1:0]      i_index,
    input  logic [hll_pkg::VAL_BITS-1:0]      i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hll_pkg::EST_BITS-1:0]      o_estimate,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [hll_pkg::ALPHA_BITS-1:0]    i_cfg_wdata
);
    import hll_pkg::*;

    t_cmd ctl;
    t_sts sts;

    hll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    hll_dp #(
        .LOG2_REGISTERS (LOG2_REGISTERS),
        .REGISTER_BITS  (REGISTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_index     (i_index),
        .i_value     (i_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_estimate  (o_estimate),
        .o_saturated (o_saturated)
    );

endmodule

// ----- hw/rtl/hll_dp.sv -----
module hll_dp #(
    parameter int LOG2_REGISTERS = hll_pkg::LOG2_REGS_DEF,
    parameter int REGISTER_BITS  = hll_pkg::REG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hll_pkg::t_cmd                     i_ctl,
    output hll_pkg::t_sts                     o_sts,
    input  logic [hll_pkg::IDX_BITS-1:0]      i_index,
    input  logic [hll_pkg::VAL_BITS-1:0]      i_value,
    input  logic                              i_cfg_we,
    input  logic [hll_pkg::ALPHA_BITS-1:0]    i_cfg_wdata,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [hll_pkg::EST_BITS-1:0]      o_estimate,
    output logic                              o_saturated
);
    import hll_pkg::*;

    localparam int L   = LOG2_REGISTERS;
    localparam int RB  = REGISTER_BITS;
    localparam int M   = 1 << L;
    localparam int SW  = FRAC_BITS + 1 + L;              // sum width, holds M * 1.0
    localparam int VW  = (RB > VAL_BITS) ? RB : VAL_BITS;
    localparam int CW  = (L > 6) ? L : 6;                // counter covers walk and divide
    localparam logic [VW-1:0] REG_MAX = VW'((1 << RB) - 1);

    // Register store
    logic [RB-1:0] r_mem [M];
    logic [RB-1:0] r_rd_data;
    logic [L-1:0]  rd_addr;
    logic [L-1:0]  wr_addr;
    logic [RB-1:0] wr_data;
    logic          wr_en;

    // Shared counter
    logic [CW-1:0] r_cnt;

    // Merge capture
    logic [L-1:0]  r_idx;
    logic [RB-1:0] r_val;
    logic [VW-1:0] val_ext;
    logic [RB-1:0] val_sat;

    // Sum and divide
    logic          r_acc_en;
    logic [SW-1:0] r_acc;
    logic [8:0]    r9;
    logic [6:0]    sh;
    logic [SW-1:0] term;
    logic [SW-1:0] num_hi;
    logic [SW:0]   rem2;
    logic [SW:0]   diff;
    logic          q_bit;
    logic [SW-1:0] r_rem;
    logic [EST_BITS-1:0] r_q;
    logic          r_sat;

    // Config and output
    logic [ALPHA_BITS-1:0] r_alpha;
    logic                  r_out_vld;
    logic [EST_BITS-1:0]   r_est;
    logic                  r_out_sat;

    // Shared counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_sts.cnt_mem_last = (r_cnt[L-1:0] == {L{1'b1}});
    assign o_sts.cnt_div_last = (r_cnt == CW'(DIV_STEPS - 1));
    assign o_sts.out_free     = !r_out_vld || !i_out_stall;

    // Merge value clipped to register range
    assign val_ext = VW'(i_value);
    assign val_sat = (val_ext > REG_MAX) ? RB'(REG_MAX) : RB'(val_ext);

    always_ff @(posedge i_clk) begin
        if (i_ctl.merge_cap) begin
            r_idx <= L'(i_index);
            r_val <= val_sat;
        end
    end

    // Store ports: one write, one registered read
    assign rd_addr = i_ctl.rd_in ? L'(i_index) : r_cnt[L-1:0];
    assign wr_en   = i_ctl.clr_wr || i_ctl.merge_wr;
    assign wr_addr = i_ctl.clr_wr ? r_cnt[L-1:0] : r_idx;
    assign wr_data = i_ctl.clr_wr ? '0 : ((r_val > r_rd_data) ? r_val : r_rd_data);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Term 2^-r in 64-bit fraction; nothing for r above 64
    assign r9   = 9'(r_rd_data);
    assign sh   = 7'(9'd64 - r9);
    assign term = (r9 <= 9'd64) ? (SW'(1) << sh) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_ctl.sum_rd;
        end
    end

    // Harmonic sum accumulator
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (r_acc_en) begin
            r_acc <= r_acc + term;
        end
    end

    // Numerator alpha*2^(2L+48): its top part alpha<<2L seeds the remainder,
    // the low 48 zero bits are shifted in one per step
    assign num_hi = SW'(r_alpha) << (2 * L);
    assign rem2   = {r_rem, 1'b0};
    assign diff   = rem2 - {1'b0, r_acc};
    assign q_bit  = (rem2 >= {1'b0, r_acc});

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.div_init) begin
            r_rem <= num_hi;
            r_q   <= '0;
            r_sat <= (num_hi >= r_acc);
        end else if (i_ctl.div_step) begin
            r_rem <= q_bit ? diff[SW-1:0] : rem2[SW-1:0];
            r_q   <= {r_q[EST_BITS-2:0], q_bit};
        end
    end

    // Alpha register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg_we) begin
            r_alpha <= i_cfg_wdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_est     <= r_sat ? {EST_BITS{1'b1}} : r_q;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_estimate  = r_est;
    assign o_saturated = r_out_sat;

endmodule

// ----- hw/rtl/hll_ctrl.sv -----
module hll_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cmd,
    output logic          o_in_stall,
    input  hll_pkg::t_sts i_sts,
    output hll_pkg::t_cmd o_ctl
);
    import hll_pkg::*;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MWR   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_INIT  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_CLR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.cnt_mem_last) begin
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                o_ctl.rd_in   = 1'b1;
                o_ctl.cnt_clr = 1'b1;
                if (accept) begin
                    if (i_cmd == CMD_MERGE) begin
                        o_ctl.merge_cap = 1'b1;
                        n_state         = ST_MWR;
                    end else begin
                        o_ctl.acc_clr = 1'b1;
                        n_state       = ST_SUM;
                    end
                end
            end
            ST_MWR: begin
                o_ctl.merge_wr = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_SUM: begin
                o_ctl.sum_rd = 1'b1;
                if (i_sts.cnt_mem_last) begin
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = ST_DRAIN;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_INIT;
            end
            ST_INIT: begin
                o_ctl.div_init = 1'b1;
                o_ctl.cnt_clr  = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.cnt_div_last) begin
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_ctl.cnt_inc = 1'b1;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/hll_chk.sv -----
module hll_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [hll_pkg::EST_BITS-1:0]      o_estimate,
    input logic                              o_saturated
);
    import hll_pkg::*;

    // Stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_estimate)
            && $stable(o_saturated))
        else $error("output word changed under stall");

    // Saturated estimate reads as the maximum
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> o_estimate == {EST_BITS{1'b1}})
        else $error("saturated estimate not clamped");

    // Store clearing follows reset: no word taken right after it
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input open during clearing pass");

    // Every accepted word leaves the block busy, with the input stalled, once it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("word accepted without busy cycle");

endmodule

bind hyperloglog_merge_estimate hll_chk u_hll_chk (.*);

// ----- verif/hyperloglog_merge_estimate_test.sv -----
module hyperloglog_merge_estimate_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hll_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int NUM_REGS     = 2 ** LOG2_REGS_DEF;
    localparam int REG_MAX      = 2 ** REG_BITS_DEF - 1;
    localparam int EST_LATENCY  = NUM_REGS + 53;
    localparam int MERGE_SETTLE = 4;
    localparam int IDLE_LIMIT   = 4 * EST_LATENCY;

    // One result word
    typedef struct packed {
        logic [EST_BITS-1:0] est;
        logic                sat;
    } t_est;

    // Directed table: a data word or an alpha write
    typedef enum logic {ROW_WORD, ROW_ALPHA} t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic                  cmd;
        logic [IDX_BITS-1:0]   index;
        logic [ALPHA_BITS-1:0] data;    // value for words, alpha for writes
        logic                  typed;   // result below is fixed, not predicted
        t_est                  want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_cmd = CMD_MERGE;
    logic [IDX_BITS-1:0]   i_index = '0;
    logic [VAL_BITS-1:0]   i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [EST_BITS-1:0]   o_estimate;
    logic                  o_saturated;
    logic                  i_cfg_we = 1'b0;
    logic [ALPHA_BITS-1:0] i_cfg_wdata = ALPHA_RESET;

    // Shadow sketch, running harmonic sum (64 fraction bits) and alpha
    logic [REG_BITS_DEF-1:0] sketch [NUM_REGS];
    logic [127:0]            harm_sum;
    logic [ALPHA_BITS-1:0]   alpha_q16;

    t_est pending_estimates [$];
    t_row plan [18];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    hyperloglog_merge_estimate DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_estimate  (o_estimate),
        .o_saturated (o_saturated),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // 2^-r in 2^-64 units; terms past 64 truncate to nothing
    function automatic logic [127:0] inv_pow2(input logic [REG_BITS_DEF-1:0] r);
        if (int'(r) > FRAC_BITS) return '0;
        return 128'(1) << (FRAC_BITS - int'(r));
    endfunction

    function automatic void sketch_clear();
        for (int n = 0; n < NUM_REGS; n++) sketch[n] = '0;
        harm_sum  = 128'(NUM_REGS) << FRAC_BITS;
        alpha_q16 = ALPHA_RESET;
    endfunction

    // Keep the larger register value, adjusting the sum in place
    function automatic void sketch_merge(input logic [IDX_BITS-1:0] idx,
                                         input logic [VAL_BITS-1:0] val);
        logic [LOG2_REGS_DEF-1:0] slot;
        logic [REG_BITS_DEF-1:0]  level;
        slot  = idx[LOG2_REGS_DEF-1:0];
        level = (int'(val) > REG_MAX) ? REG_BITS_DEF'(REG_MAX) : REG_BITS_DEF'(val);
        if (level > sketch[slot]) begin
            harm_sum     = harm_sum - inv_pow2(sketch[slot]) + inv_pow2(level);
            sketch[slot] = level;
        end
    endfunction

    // floor(alpha * 2^(2*log2m+48) / sum), clamped to 48 bits
    function automatic t_est harmonic_estimate();
        logic [127:0] scaled;
        logic [127:0] quo;
        t_est         res;
        if (harm_sum == '0) begin
            res.est = '1;
            res.sat = 1'b1;
        end else begin
            scaled = 128'(alpha_q16) << (2 * LOG2_REGS_DEF + EST_BITS);
            quo    = scaled / harm_sum;
            res.sat = (quo[127:EST_BITS] != '0);
            res.est = res.sat ? '1 : quo[EST_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one word, hold it until taken, then update the shadow state
    task automatic send_word(input logic cmd, input logic [IDX_BITS-1:0] idx,
                             input logic [VAL_BITS-1:0] val, input logic typed,
                             input t_est fixed);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_index    <= idx;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (cmd == CMD_MERGE) sketch_merge(idx, val);
        else pending_estimates.push_back(typed ? fixed : harmonic_estimate());
    endtask

    // Drain all pending estimates, then let in-flight merges land
    task automatic wait_idle(input int settle);
        i_in_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_alpha(input logic [ALPHA_BITS-1:0] val);
        wait_idle(MERGE_SETTLE);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        alpha_q16 = val;
    endtask

    // Merges spread over the sketch, a hot window and the end slots,
    // with an estimate now and then
    task automatic random_phase(input int n_words, input int min_ests);
        int                  sent;
        int                  ests;
        logic                cmd;
        logic [IDX_BITS-1:0] idx;
        logic [VAL_BITS-1:0] val;
        logic [IDX_BITS-1:0] hot_base;
        sent     = 0;
        ests     = 0;
        hot_base = IDX_BITS'($urandom);
        while (sent < n_words || ests < min_ests) begin
            cmd = ($urandom_range(11, 0) == 0) ? CMD_ESTIMATE : CMD_MERGE;
            case ($urandom_range(3, 0))
                0: idx = hot_base + IDX_BITS'($urandom_range(7, 0));
                1: idx = $urandom_range(1, 0) ? '1 : '0;
                default: idx = IDX_BITS'($urandom);
            endcase
            case ($urandom_range(3, 0))
                0: val = $urandom_range(1, 0) ? '1 : '0;
                default: val = VAL_BITS'($urandom_range(63, 0));
            endcase
            send_word(cmd, idx, val, 1'b0, '0);
            sent++;
            if (cmd == CMD_ESTIMATE) ests++;
        end
    endtask

    // Output check and receiver stall
    always @(posedge i_clk) begin : out_check
        t_est want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_estimates.size() == 0) begin
                report_mismatch("word with no estimate pending", 64'(o_estimate), 64'd0);
            end else begin
                want = pending_estimates.pop_front();
                if (o_estimate !== want.est)
                    report_mismatch("estimate", 64'(o_estimate), 64'(want.est));
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", 64'(o_saturated), 64'(want.sat));
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        sketch_clear();
        plan = '{
            // cleared sketch: sum is m, so the estimate is alpha*m
            '{ROW_WORD,  CMD_ESTIMATE, 14'd0,      16'd0,     1'b1, '{48'd11818, 1'b0}},
            '{ROW_ALPHA, CMD_MERGE,    14'd0,      16'd0,     1'b0, '0},
            '{ROW_WORD,  CMD_ESTIMATE, 14'd0,      16'd0,     1'b1, '{48'd0, 1'b0}},
            '{ROW_ALPHA, CMD_MERGE,    14'd0,      16'hFFFF,  1'b0, '0},
            '{ROW_WORD,  CMD_ESTIMATE, 14'd0,      16'd0,     1'b1, '{48'd16383, 1'b0}},
            // end slots, largest value, and smaller values that must not lower
            '{ROW_WORD,  CMD_MERGE,    14'd0,      16'd63,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'h3FFF,   16'd63,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'd0,      16'd0,     1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'h2AAA,   16'h2A,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'h1555,   16'h15,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'h1555,   16'h16,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'h1555,   16'h01,    1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'd5,      16'd1,     1'b0, '0},
            // estimate with index and value set: both are ignored
            '{ROW_WORD,  CMD_ESTIMATE, 14'h3FFF,   16'd63,    1'b0, '0},
            '{ROW_ALPHA, CMD_MERGE,    14'd0,      ALPHA_RESET, 1'b0, '0},
            '{ROW_WORD,  CMD_ESTIMATE, 14'd0,      16'd0,     1'b0, '0},
            '{ROW_WORD,  CMD_MERGE,    14'd0,      16'd0,     1'b0, '0},
            '{ROW_WORD,  CMD_ESTIMATE, 14'h2AAA,   16'h15,    1'b0, '0}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 15;
        recv_idle_pct = 81;
        foreach (plan[n]) begin
            if (plan[n].kind == ROW_ALPHA) begin
                set_alpha(plan[n].data);
            end else begin
                send_word(plan[n].cmd, plan[n].index, plan[n].data[VAL_BITS-1:0],
                          plan[n].typed, plan[n].want);
            end
        end
        set_alpha(ALPHA_BITS'($urandom));
        random_phase(134, 10);

        // sender idles heavily, receiver lightly
        set_alpha(16'd1);
        send_idle_pct = 81;
        recv_idle_pct = 15;
        random_phase(133, 10);

        // back to back
        set_alpha(ALPHA_BITS'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(133, 10);
        send_word(CMD_ESTIMATE, '0, '0, 1'b0, '0);
        set_alpha(16'hFFFF);
        send_word(CMD_ESTIMATE, '0, '0, 1'b0, '0);
        set_alpha(16'd1);
        send_word(CMD_ESTIMATE, '0, '0, 1'b0, '0);

        // let any stray word show up before the verdict
        wait_idle(EST_LATENCY + 16);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/hll_pkg.sv
hw/rtl/hll_dp.sv
hw/rtl/hll_ctrl.sv
hw/rtl/hyperloglog_merge_estimate.sv
hw/rtl/hll_chk.sv
verif/hyperloglog_merge_estimate_test.sv
